@@ sv/aad_pkg.sv @@
package aad_pkg;

    localparam int MAX_FRAME_WIDTH_DEF  = 4096;
    localparam int MAX_FRAME_HEIGHT_DEF = 4096;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CHAN_W    = 8;
    localparam int POS_W     = 12;
    localparam int SUM_W     = 32;
    localparam int DIVD_W    = 34;
    localparam int DIVS_W    = 26;

    localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 13'd480;
    localparam logic [CFG_W-1:0] RST_MAX_WIDTH     = 13'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH     = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic [POS_W-1:0]  out_column;
        logic [POS_W-1:0]  out_line;
        logic              frame_done;
    } pixel_out_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_resp_t;

endpackage

@@ sv/aad_ram.sv @@
module aad_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 96
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/aad_div.sv @@
module aad_div (
    input  logic              clk,
    input  logic              rst_n,
    input  aad_pkg::div_req_t  req,
    output aad_pkg::div_resp_t resp
);

    import aad_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [DIVS_W:0]   trial;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIVS_W'(trial - {1'b0, dvs_reg}) : trial[DIVS_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], ge};
            if (step_reg == STEP_W'(DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign resp.done     = done_reg;
    assign resp.quotient = quo_reg;

endmodule

@@ sv/area_average_downscaler.sv @@
// Pass-through: a result is registered and appears in the cycle after its request; one request
// per cycle while result_stall does not hold it. Downscaling: a request is added into the sum
// memory, then waits for each division it needs in the shared bit-serial divider (three for
// the channel means when a box closes, one for the next column or row span) and for a mean to
// be loaded, taking no request meanwhile. Reset and every register write start a clearing pass
// over the sum memory's MAX_FRAME_WIDTH entries, then up to three divisions, taking no request.
module area_average_downscaler #(
    parameter int MAX_FRAME_WIDTH  = aad_pkg::MAX_FRAME_WIDTH_DEF,
    parameter int MAX_FRAME_HEIGHT = aad_pkg::MAX_FRAME_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  aad_pkg::pixel_in_t              pixel,
    output logic                            result_valid,
    input  logic                            result_stall,
    output aad_pkg::pixel_out_t             result,
    input  logic                            cfg_write,
    input  logic [aad_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aad_pkg::CFG_W-1:0]       cfg_data
);

    import aad_pkg::*;

    localparam int ADDR_W = $clog2(MAX_FRAME_WIDTH);
    localparam int MEM_W  = 3 * SUM_W;
    localparam logic [14:0] MAXW = 15'(MAX_FRAME_WIDTH);
    localparam logic [14:0] MAXH = 15'(MAX_FRAME_HEIGHT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_FRAME_WIDTH - 1);

    typedef enum logic [11:0] {
        ST_CLEAR     = 12'b0000_0000_0001,
        ST_INIT_SH   = 12'b0000_0000_0010,
        ST_INIT_CEND = 12'b0000_0000_0100,
        ST_INIT_Y1   = 12'b0000_0000_1000,
        ST_IDLE      = 12'b0000_0001_0000,
        ST_ADD       = 12'b0000_0010_0000,
        ST_DIV_R     = 12'b0000_0100_0000,
        ST_DIV_G     = 12'b0000_1000_0000,
        ST_DIV_B     = 12'b0001_0000_0000,
        ST_EMIT      = 12'b0010_0000_0000,
        ST_COL_DIV   = 12'b0100_0000_0000,
        ST_LINE_DIV  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] sw_reg, sw_next, shgt_reg, shgt_next, mw_reg, mw_next;
    logic [CFG_W-1:0] src_col_reg, src_col_next, src_line_reg, src_line_next;
    logic [CFG_W-1:0] out_col_reg, out_col_next, out_line_reg, out_line_next;
    logic [CFG_W-1:0] x0_reg, x0_next, cend_reg, cend_next, cend0_reg, cend0_next;
    logic [CFG_W-1:0] y0_reg, y0_next, y1_reg, y1_next, y10_reg, y10_next;
    logic [CFG_W-1:0] sh_reg, sh_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic issued_reg, issued_next, col_pend_reg, col_pend_next;
    logic line_pend_reg, line_pend_next, rvalid_reg, rvalid_next;

    pixel_in_t        pix_reg, pix_next;
    logic [SUM_W-1:0] sum_r_reg, sum_r_next, sum_g_reg, sum_g_next, sum_b_reg, sum_b_next;
    logic [DIVS_W-1:0] cnt_reg, cnt_next;
    logic [CHAN_W-1:0] mr_reg, mr_next, mg_reg, mg_next, mb_reg, mb_next;
    logic [POS_W-1:0] stg_col_reg, stg_col_next, stg_line_reg, stg_line_next;
    logic             stg_done_reg, stg_done_next;
    pixel_out_t       result_reg, result_next;

    logic [CFG_W-1:0]  w_eff, h_eff;
    logic              scaling, out_free, accept;
    logic              last_col, last_row, col_end, line_hit, emit;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, col_addr;
    logic [MEM_W-1:0]  mem_wdata, mem_rdata;
    logic [SUM_W-1:0]  new_r, new_g, new_b;
    logic [DIVS_W-1:0] cnt_prod;
    logic [DIVS_W-1:0] sh_prod;
    logic [27:0]       col_prod, line_prod;
    logic [13:0]       col_ext;
    logic [CFG_W-1:0]  q13, sh_q;
    div_req_t          div_req;
    div_resp_t         div_resp;

    assign w_eff = (sw_reg == '0) ? CFG_W'(1) :
                   ({2'b0, sw_reg} > MAXW) ? MAXW[CFG_W-1:0] : sw_reg;
    assign h_eff = (shgt_reg == '0) ? CFG_W'(1) :
                   ({2'b0, shgt_reg} > MAXH) ? MAXH[CFG_W-1:0] : shgt_reg;
    assign scaling = (mw_reg != '0) && (mw_reg < w_eff);

    assign out_free = !rvalid_reg || !result_stall;
    assign pixel_stall = !((state_reg == ST_IDLE) && (scaling || out_free));
    assign accept = pixel_valid && !pixel_stall;

    assign col_ext  = {1'b0, out_col_reg};
    assign col_addr = col_ext[ADDR_W-1:0];

    assign last_col = ({1'b0, src_col_reg} + 14'd1) >= {1'b0, w_eff};
    assign last_row = ({1'b0, src_line_reg} + 14'd1) >= {1'b0, h_eff};
    assign col_end  = ({1'b0, src_col_reg} + 14'd1) >= {1'b0, cend_reg};
    assign line_hit = ({1'b0, src_line_reg} + 14'd1) >= {1'b0, y1_reg};
    assign emit     = col_end && line_hit;

    assign new_r = mem_rdata[SUM_W-1:0] + SUM_W'(pix_reg.red_in);
    assign new_g = mem_rdata[2*SUM_W-1:SUM_W] + SUM_W'(pix_reg.green_in);
    assign new_b = mem_rdata[3*SUM_W-1:2*SUM_W] + SUM_W'(pix_reg.blue_in);

    assign cnt_prod  = {13'b0, cend_reg - x0_reg} * {13'b0, y1_reg - y0_reg};
    assign sh_prod   = {13'b0, h_eff} * {13'b0, mw_reg};
    assign col_prod  = 28'(col_ext + 14'd1) * 28'(w_eff);
    assign line_prod = 28'({1'b0, out_line_reg} + 14'd1) * 28'(h_eff);

    assign q13  = div_resp.quotient[CFG_W-1:0];
    assign sh_q = (div_resp.quotient == '0) ? CFG_W'(1) : q13;

    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_ADD);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_reg : col_addr;
    assign mem_wdata = ((state_reg == ST_CLEAR) || emit) ? '0 : {new_b, new_g, new_r};
    assign mem_re    = accept && scaling;

    always_comb
    begin
        div_req.dividend = '0;
        div_req.divisor  = DIVS_W'(1);
        unique case (state_reg)
            ST_INIT_SH:
            begin
                div_req.dividend = DIVD_W'(sh_prod) + DIVD_W'(w_eff[CFG_W-1:1]);
                div_req.divisor  = DIVS_W'(w_eff);
            end
            ST_INIT_CEND:
            begin
                div_req.dividend = DIVD_W'(w_eff);
                div_req.divisor  = DIVS_W'(mw_reg);
            end
            ST_INIT_Y1:
            begin
                div_req.dividend = DIVD_W'(h_eff);
                div_req.divisor  = DIVS_W'(sh_reg);
            end
            ST_DIV_R:
            begin
                div_req.dividend = DIVD_W'(sum_r_reg) + DIVD_W'(cnt_reg[DIVS_W-1:1]);
                div_req.divisor  = cnt_reg;
            end
            ST_DIV_G:
            begin
                div_req.dividend = DIVD_W'(sum_g_reg) + DIVD_W'(cnt_reg[DIVS_W-1:1]);
                div_req.divisor  = cnt_reg;
            end
            ST_DIV_B:
            begin
                div_req.dividend = DIVD_W'(sum_b_reg) + DIVD_W'(cnt_reg[DIVS_W-1:1]);
                div_req.divisor  = cnt_reg;
            end
            ST_COL_DIV:
            begin
                div_req.dividend = DIVD_W'(col_prod);
                div_req.divisor  = DIVS_W'(mw_reg);
            end
            ST_LINE_DIV:
            begin
                div_req.dividend = DIVD_W'(line_prod);
                div_req.divisor  = DIVS_W'(sh_reg);
            end
            default:
            begin
                div_req.dividend = '0;
                div_req.divisor  = DIVS_W'(1);
            end
        endcase
        div_req.start = !issued_reg &&
            ((state_reg == ST_INIT_SH) || (state_reg == ST_INIT_CEND) ||
             (state_reg == ST_INIT_Y1) || (state_reg == ST_DIV_R) ||
             (state_reg == ST_DIV_G) || (state_reg == ST_DIV_B) ||
             (state_reg == ST_COL_DIV) || (state_reg == ST_LINE_DIV));
    end

    always_comb
    begin
        state_next     = state_reg;
        sw_next        = sw_reg;
        shgt_next      = shgt_reg;
        mw_next        = mw_reg;
        src_col_next   = src_col_reg;
        src_line_next  = src_line_reg;
        out_col_next   = out_col_reg;
        out_line_next  = out_line_reg;
        x0_next        = x0_reg;
        cend_next      = cend_reg;
        cend0_next     = cend0_reg;
        y0_next        = y0_reg;
        y1_next        = y1_reg;
        y10_next       = y10_reg;
        sh_next        = sh_reg;
        clr_next       = clr_reg;
        issued_next    = issued_reg;
        col_pend_next  = col_pend_reg;
        line_pend_next = line_pend_reg;
        rvalid_next    = rvalid_reg && result_stall;
        pix_next       = pix_reg;
        sum_r_next     = sum_r_reg;
        sum_g_next     = sum_g_reg;
        sum_b_next     = sum_b_reg;
        cnt_next       = cnt_reg;
        mr_next        = mr_reg;
        mg_next        = mg_reg;
        mb_next        = mb_reg;
        stg_col_next   = stg_col_reg;
        stg_line_next  = stg_line_reg;
        stg_done_next  = stg_done_reg;
        result_next    = result_reg;

        if (div_req.start)
        begin
            issued_next = 1'b1;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    if (scaling)
                    begin
                        state_next = ST_INIT_SH;
                    end
                    else
                    begin
                        sh_next    = h_eff;
                        cend_next  = CFG_W'(1);
                        cend0_next = CFG_W'(1);
                        y1_next    = CFG_W'(1);
                        y10_next   = CFG_W'(1);
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end
            ST_INIT_SH:
            begin
                if (issued_reg && div_resp.done)
                begin
                    issued_next = 1'b0;
                    sh_next     = sh_q;
                    state_next  = ST_INIT_CEND;
                end
            end
            ST_INIT_CEND:
            begin
                if (issued_reg && div_resp.done)
                begin
                    issued_next = 1'b0;
                    cend_next   = q13;
                    cend0_next  = q13;
                    state_next  = ST_INIT_Y1;
                end
            end
            ST_INIT_Y1:
            begin
                if (issued_reg && div_resp.done)
                begin
                    issued_next = 1'b0;
                    y1_next     = q13;
                    y10_next    = q13;
                    state_next  = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (scaling)
                    begin
                        pix_next   = pixel;
                        state_next = ST_ADD;
                    end
                    else
                    begin
                        result_next.red_out    = pixel.red_in;
                        result_next.green_out  = pixel.green_in;
                        result_next.blue_out   = pixel.blue_in;
                        result_next.out_column = src_col_reg[POS_W-1:0];
                        result_next.out_line   = src_line_reg[POS_W-1:0];
                        result_next.frame_done = last_col && last_row;
                        rvalid_next            = 1'b1;
                        if (last_col)
                        begin
                            src_col_next  = '0;
                            src_line_next = last_row ? '0 : src_line_reg + CFG_W'(1);
                        end
                        else
                        begin
                            src_col_next = src_col_reg + CFG_W'(1);
                        end
                    end
                end
            end
            ST_ADD:
            begin
                sum_r_next    = new_r;
                sum_g_next    = new_g;
                sum_b_next    = new_b;
                cnt_next      = cnt_prod;
                stg_col_next  = out_col_reg[POS_W-1:0];
                stg_line_next = out_line_reg[POS_W-1:0];
                stg_done_next = last_col && last_row;
                col_pend_next  = 1'b0;
                line_pend_next = 1'b0;
                if (last_col)
                begin
                    src_col_next = '0;
                    out_col_next = '0;
                    x0_next      = '0;
                    cend_next    = cend0_reg;
                    if (last_row)
                    begin
                        src_line_next = '0;
                        out_line_next = '0;
                        y0_next       = '0;
                        y1_next       = y10_reg;
                    end
                    else
                    begin
                        src_line_next = src_line_reg + CFG_W'(1);
                        if (line_hit &&
                            (({1'b0, out_line_reg} + 14'd1) < {1'b0, sh_reg}))
                        begin
                            out_line_next  = out_line_reg + CFG_W'(1);
                            y0_next        = y1_reg;
                            line_pend_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    src_col_next = src_col_reg + CFG_W'(1);
                    if (col_end && (({1'b0, out_col_reg} + 14'd1) < {1'b0, mw_reg}))
                    begin
                        out_col_next  = out_col_reg + CFG_W'(1);
                        x0_next       = cend_reg;
                        col_pend_next = 1'b1;
                    end
                end
                if (emit)
                begin
                    state_next = ST_DIV_R;
                end
                else if (col_pend_next)
                begin
                    state_next = ST_COL_DIV;
                end
                else if (line_pend_next)
                begin
                    state_next = ST_LINE_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_R:
            begin
                if (issued_reg && div_resp.done)
                begin
                    issued_next = 1'b0;
                    mr_next     = div_resp.quotient[CHAN_W-1:0];
                    state_next  = ST_DIV_G;
                end
            end
            ST_DIV_G:
            begin
                if (issued_reg && div_resp.done)
                begin
                    issued_next = 1'b0;
                    mg_next     = div_resp.quotient[CHAN_W-1:0];
                    state_next  = ST_DIV_B;
                end
            end
            ST_DIV_B:
            begin
                if (issued_reg && div_resp.done)
                begin
                    issued_next = 1'b0;
                    mb_next     = div_resp.quotient[CHAN_W-1:0];
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    result_next.red_out    = mr_reg;
                    result_next.green_out  = mg_reg;
                    result_next.blue_out   = mb_reg;
                    result_next.out_column = stg_col_reg;
                    result_next.out_line   = stg_line_reg;
                    result_next.frame_done = stg_done_reg;
                    rvalid_next            = 1'b1;
                    if (col_pend_reg)
                    begin
                        state_next = ST_COL_DIV;
                    end
                    else if (line_pend_reg)
                    begin
                        state_next = ST_LINE_DIV;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_COL_DIV:
            begin
                if (issued_reg && div_resp.done)
                begin
                    issued_next   = 1'b0;
                    cend_next     = q13;
                    col_pend_next = 1'b0;
                    state_next    = line_pend_reg ? ST_LINE_DIV : ST_IDLE;
                end
            end
            ST_LINE_DIV:
            begin
                if (issued_reg && div_resp.done)
                begin
                    issued_next    = 1'b0;
                    y1_next        = q13;
                    line_pend_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase

        if (cfg_write &&
            ((cfg_index == CFG_SOURCE_WIDTH) || (cfg_index == CFG_SOURCE_HEIGHT) ||
             (cfg_index == CFG_MAX_WIDTH)))
        begin
            unique case (cfg_index)
                CFG_SOURCE_WIDTH:  sw_next   = cfg_data;
                CFG_SOURCE_HEIGHT: shgt_next = cfg_data;
                default:           mw_next   = cfg_data;
            endcase
            state_next     = ST_CLEAR;
            clr_next       = '0;
            src_col_next   = '0;
            src_line_next  = '0;
            out_col_next   = '0;
            out_line_next  = '0;
            x0_next        = '0;
            y0_next        = '0;
            issued_next    = 1'b0;
            col_pend_next  = 1'b0;
            line_pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sw_reg        <= RST_SOURCE_WIDTH;
            shgt_reg      <= RST_SOURCE_HEIGHT;
            mw_reg        <= RST_MAX_WIDTH;
            src_col_reg   <= '0;
            src_line_reg  <= '0;
            out_col_reg   <= '0;
            out_line_reg  <= '0;
            x0_reg        <= '0;
            cend_reg      <= '0;
            cend0_reg     <= '0;
            y0_reg        <= '0;
            y1_reg        <= '0;
            y10_reg       <= '0;
            sh_reg        <= '0;
            clr_reg       <= '0;
            issued_reg    <= 1'b0;
            col_pend_reg  <= 1'b0;
            line_pend_reg <= 1'b0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sw_reg        <= sw_next;
            shgt_reg      <= shgt_next;
            mw_reg        <= mw_next;
            src_col_reg   <= src_col_next;
            src_line_reg  <= src_line_next;
            out_col_reg   <= out_col_next;
            out_line_reg  <= out_line_next;
            x0_reg        <= x0_next;
            cend_reg      <= cend_next;
            cend0_reg     <= cend0_next;
            y0_reg        <= y0_next;
            y1_reg        <= y1_next;
            y10_reg       <= y10_next;
            sh_reg        <= sh_next;
            clr_reg       <= clr_next;
            issued_reg    <= issued_next;
            col_pend_reg  <= col_pend_next;
            line_pend_reg <= line_pend_next;
            rvalid_reg    <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg      <= pix_next;
        sum_r_reg    <= sum_r_next;
        sum_g_reg    <= sum_g_next;
        sum_b_reg    <= sum_b_next;
        cnt_reg      <= cnt_next;
        mr_reg       <= mr_next;
        mg_reg       <= mg_next;
        mb_reg       <= mb_next;
        stg_col_reg  <= stg_col_next;
        stg_line_reg <= stg_line_next;
        stg_done_reg <= stg_done_next;
        result_reg   <= result_next;
    end

    aad_ram #(
        .DEPTH  (MAX_FRAME_WIDTH),
        .ADDR_W (ADDR_W),
        .DATA_W (MEM_W)
    ) u_sums (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (col_addr),
        .rdata (mem_rdata)
    );

    aad_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    assign result_valid = rvalid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (state_reg == ST_IDLE))
        else $error("request taken outside the idle state");

    a_mem_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("sum memory read and written in the same cycle");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && out_free && !cfg_write |=> rvalid_reg)
        else $error("box mean was not loaded into the output register");
`endif

endmodule
